// ----- rtl/core/depth_limited_random_dfs_explorer_top_defines.svh -----
// assertion macros for the explorer checker
`ifndef DEPTH_LIMITED_RANDOM_DFS_EXPLORER_TOP_DEFINES_SVH
`define DEPTH_LIMITED_RANDOM_DFS_EXPLORER_TOP_DEFINES_SVH

// plain property, clocked on clk, off during reset
`define DLDFS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// same-cycle implication
`define DLDFS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/core/dldfs_pkg.sv -----
package dldfs_pkg;

	localparam int unsigned GRID_SIDE_DEF   = 32;
	localparam int unsigned STACK_DEPTH_DEF = 1024;

	localparam int unsigned POS_W   = 5;
	localparam int unsigned LEVEL_W = 11;
	localparam int unsigned LIMIT_W = 11;
	localparam int unsigned RESUME_W = 10;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 11;

	localparam logic [LIMIT_W-1:0]  DEPTH_LIMIT_RST  = 11'd1000;
	localparam logic [RESUME_W-1:0] RESUME_DEPTH_RST = 10'd750;
	localparam logic                LIMIT_ENABLE_RST = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_LIMIT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RESUME_DEPTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE = 2'd2;

	localparam logic [1:0] DIR_NORTH = 2'd0;
	localparam logic [1:0] DIR_SOUTH = 2'd1;
	localparam logic [1:0] DIR_WEST  = 2'd2;
	localparam logic [1:0] DIR_EAST  = 2'd3;

	typedef struct packed {
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [3:0]       open_mask;
		logic [7:0]       rand_value;
	} item_t;

	typedef struct packed {
		logic [1:0]         move_dir;
		logic               move_valid;
		logic               backtracking;
		logic               in_retreat;
		logic [LEVEL_W-1:0] stack_level;
	} result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_N,
		ST_RD_S,
		ST_RD_C,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic rd_north;
		logic rd_south;
		logic rd_cur;
		logic decide;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
	} sts_t;

	// 8-bit value mod 3: base-4 digits sum, then a small table
	function automatic logic [1:0] mod3(input logic [7:0] v);
		logic [3:0] s;
		logic [1:0] r;
		s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
		unique case (s)
			4'd0, 4'd3, 4'd6, 4'd9, 4'd12: r = 2'd0;
			4'd1, 4'd4, 4'd7, 4'd10, 4'd13: r = 2'd1;
			4'd2, 4'd5, 4'd8, 4'd11, 4'd14: r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/core/dldfs_ctrl.sv -----
module dldfs_ctrl
	import dldfs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_d = ST_RD_N;
			end
			ST_RD_N:   state_d = ST_RD_S;
			ST_RD_S:   state_d = ST_RD_C;
			ST_RD_C:   state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_IDLE;
			default:   state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_CLEAR:  cmd.clear = 1'b1;
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_RD_N:   cmd.rd_north = 1'b1;
			ST_RD_S:   cmd.rd_south = 1'b1;
			ST_RD_C:   cmd.rd_cur = 1'b1;
			ST_DECIDE: cmd.decide = 1'b1;
			default:   cmd = '0;
		endcase
	end

endmodule

// ----- rtl/core/dldfs_datapath.sv -----
module dldfs_datapath
	import dldfs_pkg::*;
#(
	parameter int unsigned GRID_SIDE   = GRID_SIDE_DEF,
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  item_t                 item,
	input  logic                  cfg_wr,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  done,
	output result_t               result
);

	localparam int unsigned CW    = $clog2(GRID_SIDE);
	localparam int unsigned PW    = ((CW > POS_W) ? CW : POS_W) + 1;
	localparam int unsigned SW    = $clog2(STACK_DEPTH);
	localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int unsigned CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
	localparam logic [PW-1:0]    GS      = PW'(GRID_SIDE);
	localparam logic [CW-1:0]    LAST_ROW = CW'(GRID_SIDE - 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);

	logic [GRID_SIDE-1:0] grid_mem [GRID_SIDE];
	logic [1:0]           stk_mem [STACK_DEPTH];

	logic [LIMIT_W-1:0]  depth_limit_q;
	logic [RESUME_W-1:0] resume_q;
	logic                enable_q;

	logic [CW-1:0]        clr_row_q;
	logic [PW-1:0]        x_q;
	logic [PW-1:0]        y_q;
	logic [3:0]           mask_q;
	logic [7:0]           rand_q;
	logic [GRID_SIDE-1:0] row_n_q;
	logic [GRID_SIDE-1:0] row_s_q;
	logic [GRID_SIDE-1:0] row_c_q;
	logic [1:0]           top_q;
	logic [CNT_W-1:0]     count_q;
	logic                 retreat_q;
	logic                 done_q;
	result_t              result_q;

	logic [PW-1:0]        xm, xp, ym, yp;
	logic                 x_on, y_on;
	logic [PW-1:0]        rd_y;
	logic [CW-1:0]        rd_addr;
	logic [CW-1:0]        x_idx;
	logic [3:0]           cand;
	logic [2:0]           n_cand;
	logic [1:0]           k;
	logic [2:0]           seen;
	logic [1:0]           pick;
	logic [GRID_SIDE-1:0] row_new;
	logic [CNT_W-1:0]     count_dec;
	logic [SW-1:0]        stk_rd_addr;

	logic             ret0;
	logic             ret_d;
	logic             valid_d;
	logic             back_d;
	logic             push;
	logic [1:0]       dir_d;
	logic [CNT_W-1:0] cnt_d;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_limit_q <= DEPTH_LIMIT_RST;
			resume_q      <= RESUME_DEPTH_RST;
			enable_q      <= LIMIT_ENABLE_RST;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				CFG_DEPTH_LIMIT:  depth_limit_q <= cfg_data[LIMIT_W-1:0];
				CFG_RESUME_DEPTH: resume_q <= cfg_data[RESUME_W-1:0];
				CFG_LIMIT_ENABLE: enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// visited map clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_row_q <= '0;
		end else if (cmd.clear) begin
			clr_row_q <= clr_row_q + 1'b1;
		end
	end

	assign sts.clear_last = (clr_row_q == LAST_ROW);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= PW'(item.pos_x);
			y_q    <= PW'(item.pos_y);
			mask_q <= item.open_mask;
			rand_q <= item.rand_value;
		end
	end

	assign xm   = x_q - 1'b1;
	assign xp   = x_q + 1'b1;
	assign ym   = y_q - 1'b1;
	assign yp   = y_q + 1'b1;
	assign x_on = (x_q < GS);
	assign y_on = (y_q < GS);
	assign x_idx = x_q[CW-1:0];

	always_comb begin
		rd_y = y_q;
		if (cmd.rd_north) rd_y = ym;
		else if (cmd.rd_south) rd_y = yp;
	end

	assign rd_addr = rd_y[CW-1:0];

	// visited map: one row read or written per cycle
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			grid_mem[clr_row_q] <= '0;
		end else if (cmd.decide && x_on && y_on) begin
			grid_mem[y_q[CW-1:0]] <= row_new;
		end
		if (cmd.rd_north) row_n_q <= grid_mem[rd_addr];
		if (cmd.rd_south) row_s_q <= grid_mem[rd_addr];
		if (cmd.rd_cur)   row_c_q <= grid_mem[rd_addr];
	end

	assign count_dec   = count_q - 1'b1;
	assign stk_rd_addr = count_dec[SW-1:0];

	// return stack
	always_ff @(posedge clk) begin
		if (cmd.decide && push) begin
			stk_mem[count_q[SW-1:0]] <= pick ^ 2'b01;
		end
		if (cmd.rd_north && (count_q != '0)) begin
			top_q <= stk_mem[stk_rd_addr];
		end
	end

	always_comb begin
		cand            = '0;
		cand[DIR_NORTH] = mask_q[DIR_NORTH] && (ym < GS) && x_on && !row_n_q[x_idx];
		cand[DIR_SOUTH] = mask_q[DIR_SOUTH] && (yp < GS) && x_on && !row_s_q[x_idx];
		cand[DIR_WEST]  = mask_q[DIR_WEST] && (xm < GS) && y_on && !row_c_q[xm[CW-1:0]];
		cand[DIR_EAST]  = mask_q[DIR_EAST] && (xp < GS) && y_on && !row_c_q[xp[CW-1:0]];
	end

	assign n_cand = 3'($countones(cand));

	always_comb begin
		unique case (n_cand)
			3'd2:    k = {1'b0, rand_q[0]};
			3'd3:    k = mod3(rand_q);
			3'd4:    k = rand_q[1:0];
			default: k = 2'd0;
		endcase
	end

	always_comb begin
		pick = DIR_NORTH;
		seen = '0;
		for (int i = 0; i < 4; i++) begin
			if (cand[i]) begin
				if (seen == {1'b0, k}) pick = 2'(i);
				seen = seen + 1'b1;
			end
		end
	end

	always_comb begin
		ret0 = retreat_q;
		if (!enable_q) ret0 = 1'b0;
		else if (CMP_W'(count_q) >= CMP_W'(depth_limit_q)) ret0 = 1'b1;
	end

	always_comb begin
		row_new        = row_c_q;
		row_new[x_idx] = !ret0;
	end

	always_comb begin
		dir_d   = DIR_NORTH;
		valid_d = 1'b0;
		back_d  = 1'b0;
		push    = 1'b0;
		ret_d   = ret0;
		cnt_d   = count_q;
		if (ret0) begin
			if (count_q != '0) begin
				dir_d   = top_q;
				valid_d = 1'b1;
				back_d  = 1'b1;
				cnt_d   = count_dec;
				if (CMP_W'(count_dec) == CMP_W'(resume_q)) ret_d = 1'b0;
			end else begin
				ret_d = 1'b0;
			end
		end else if (cand != '0) begin
			dir_d   = pick;
			valid_d = 1'b1;
			if (count_q < DEPTH_C) begin
				push  = 1'b1;
				cnt_d = count_q + 1'b1;
			end
		end else if (count_q != '0) begin
			dir_d   = top_q;
			valid_d = 1'b1;
			back_d  = 1'b1;
			cnt_d   = count_dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			retreat_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.decide;
			if (cmd.decide) begin
				count_q   <= cnt_d;
				retreat_q <= ret_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			result_q.move_dir     <= dir_d;
			result_q.move_valid   <= valid_d;
			result_q.backtracking <= back_d;
			result_q.in_retreat   <= ret_d;
			result_q.stack_level  <= LEVEL_W'(cnt_d);
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- rtl/core/depth_limited_random_dfs_explorer_top.sv -----
// randomized depth-first maze explorer with depth-limited retreat
//
// item channel: an item (cell, open mask, random byte) is taken at a rising
// edge where start is high and busy is low. busy stays high while the item
// is worked on.
// result channel: done is high for exactly one cycle with result valid;
// the receiver cannot stall, so the result must be taken in that cycle.
// the item is then worked through the states RD_N, RD_S, RD_C and DECIDE
// in that order, and done is registered from DECIDE. the single-port
// visited map reads the north, south and current rows one per cycle
// in RD_N, RD_S and RD_C, before the decision.
// a new item may be taken in the same cycle that done is shown.
// config channel: cfg_valid/cfg_ready write depth_limit (0), resume_depth
// (1) and limit_enable (2); cfg_ready is always high, write while idle.
// reset: stack and retreat state clear, registers take their defaults, and
// the visited map is swept clean one row a cycle, with busy held high;
// config writes are taken during the sweep.
module depth_limited_random_dfs_explorer_top
	import dldfs_pkg::*;
#(
	parameter int unsigned GRID_SIDE   = GRID_SIDE_DEF,
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  item_t                 item,
	output logic                  done,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	dldfs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	dldfs_datapath #(
		.GRID_SIDE   (GRID_SIDE),
		.STACK_DEPTH (STACK_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.item      (item),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

endmodule

// ----- rtl/core/dldfs_checker.sv -----
`include "depth_limited_random_dfs_explorer_top_defines.svh"

module dldfs_checker
	import dldfs_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input result_t result
);

	`DLDFS_ASSERT(a_latency, (start && !busy) |-> ##5 done, "result not delivered 5 cycles after transfer")
	`DLDFS_ASSERT_IMP(a_done_idle, done, !busy, "result shown while busy")
	`DLDFS_ASSERT_IMP(a_no_move, done && !result.move_valid, (result.move_dir == 2'd0) && !result.backtracking && !result.in_retreat && (result.stack_level == '0), "no-move result with stale fields")
	`DLDFS_ASSERT_IMP(a_retreat_pops, done && result.in_retreat, result.backtracking && result.move_valid, "retreat step without a pop")

endmodule

bind depth_limited_random_dfs_explorer_top dldfs_checker u_checker (.*);
